FILE: design/mpd_pkg.sv
// Shared types and constants for the Manchester pulse decoder.
package mpd_pkg;

	localparam int TICK_W = 16;
	localparam int BYTE_W = 8;
	localparam int IDX_W  = 3;
	localparam int CFG_IDX_W = 2;

	localparam logic [TICK_W-1:0] SHORT_MIN_RST = 16'd360;
	localparam logic [TICK_W-1:0] SHORT_MAX_RST = 16'd680;
	localparam logic [BYTE_W-1:0] PREAMBLE_RST  = 8'hAB;

	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MAX = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PREAMBLE  = 2'd2;

	typedef struct packed {
		logic is_short;
		logic is_long;
	} pulse_class_t;

	typedef struct packed {
		logic              in_sync;
		logic              half_bit_seen;
		logic [BYTE_W-1:0] bit_history;
		logic              byte_aligned;
		logic [IDX_W-1:0]  bit_index;
		logic [BYTE_W-1:0] byte_accum;
	} dec_state_t;

endpackage

FILE: design/manchester_pulse_decoder.sv
// An accepted edge transaction is held in the input register (stage 1); any byte it
// completes goes to the result register. Throughput: one edge transaction per cycle
// while out_ready is high; a waiting byte blocks stage 1, so the next edge waits.
// A stall on out_ready holds the input register, which then holds in_ready low.
// Reset (arst_n low, asynchronous) clears sync state, valid flags and restores
// short_min 360, short_max 680, preamble 0xAB.
module manchester_pulse_decoder import mpd_pkg::*; #(
	parameter logic [TICK_W-1:0] SHORT_MIN_INIT = SHORT_MIN_RST,
	parameter logic [TICK_W-1:0] SHORT_MAX_INIT = SHORT_MAX_RST,
	parameter logic [BYTE_W-1:0] PREAMBLE_INIT  = PREAMBLE_RST
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [TICK_W-1:0]    pulse_ticks,
	input  logic                 line_level,
	input  logic                 timed_out,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [BYTE_W-1:0]    rx_byte,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]    cfg_data
);
	logic [TICK_W-1:0] short_min_q;
	logic [TICK_W-1:0] short_max_q;
	logic [BYTE_W-1:0] preamble_q;

	logic              valid_s1;
	logic [TICK_W-1:0] ticks_s1;
	logic              level_s1;
	logic              tmo_s1;

	logic              out_valid_q;
	logic [BYTE_W-1:0] rx_byte_q;

	pulse_class_t      cls;
	logic              step;
	logic              emit;
	logic [BYTE_W-1:0] emit_byte;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_min_q <= SHORT_MIN_INIT;
			short_max_q <= SHORT_MAX_INIT;
			preamble_q  <= PREAMBLE_INIT;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SHORT_MIN: short_min_q <= cfg_data;
				CFG_SHORT_MAX: short_max_q <= cfg_data;
				CFG_PREAMBLE:  preamble_q  <= cfg_data[BYTE_W-1:0];
				default: ;
			endcase
		end
	end

	// stage 1 is processed whenever the result register can take a byte
	assign step     = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ticks_s1 <= pulse_ticks;
			level_s1 <= line_level;
			tmo_s1   <= timed_out;
		end
	end

	mpd_classify u_classify (
		.ticks     (ticks_s1),
		.short_min (short_min_q),
		.short_max (short_max_q),
		.cls       (cls)
	);

	mpd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.cls       (cls),
		.level     (level_s1),
		.tmo       (tmo_s1),
		.preamble  (preamble_q),
		.emit      (emit),
		.emit_byte (emit_byte)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			rx_byte_q <= emit_byte;
		end
	end

	assign out_valid = out_valid_q;
	assign rx_byte   = rx_byte_q;

endmodule

FILE: design/mpd_classify.sv
// Sorts a pulse width into the half-bit and whole-bit windows.
module mpd_classify import mpd_pkg::*; (
	input  logic [TICK_W-1:0] ticks,
	input  logic [TICK_W-1:0] short_min,
	input  logic [TICK_W-1:0] short_max,
	output pulse_class_t      cls
);
	logic [TICK_W:0] ticks_x;
	logic [TICK_W:0] long_min;
	logic [TICK_W:0] long_max;

	// long window bounds are doubled in one extra bit, so they never wrap
	assign ticks_x  = {1'b0, ticks};
	assign long_min = {short_min, 1'b0};
	assign long_max = {short_max, 1'b0};

	assign cls.is_short = (ticks >= short_min) && (ticks <= short_max);
	assign cls.is_long  = (ticks_x >= long_min) && (ticks_x <= long_max);

endmodule

FILE: design/mpd_core.sv
// Sync state machine, bit history, preamble match and byte assembly.
module mpd_core import mpd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  pulse_class_t      cls,
	input  logic              level,
	input  logic              tmo,
	input  logic [BYTE_W-1:0] preamble,
	output logic              emit,
	output logic [BYTE_W-1:0] emit_byte
);
	dec_state_t st_q;
	dec_state_t st_d;

	always_comb begin
		logic done;
		logic skip_match;
		logic [BYTE_W-1:0] acc_sh;
		st_d       = st_q;
		done       = 1'b0;
		skip_match = 1'b0;
		emit       = 1'b0;
		acc_sh     = {st_q.byte_accum[BYTE_W-2:0], level};
		emit_byte  = acc_sh;
		if (tmo) begin
			st_d.in_sync       = 1'b0;
			st_d.half_bit_seen = 1'b0;
			st_d.byte_aligned  = 1'b0;
			st_d.bit_history   = '0;
		end else if (!st_q.in_sync) begin
			if (cls.is_long) begin
				st_d.in_sync     = 1'b1;
				st_d.bit_history = {{(BYTE_W-1){1'b0}}, level};
			end
		end else begin
			priority if (cls.is_short) begin
				st_d.half_bit_seen = !st_q.half_bit_seen;
				done               = st_q.half_bit_seen;
			end else if (cls.is_long) begin
				if (st_q.half_bit_seen) begin
					// long pulse mid-bit: lose sync, keep history
					st_d.in_sync       = 1'b0;
					st_d.half_bit_seen = 1'b0;
					st_d.byte_aligned  = 1'b0;
					skip_match         = 1'b1;
				end else begin
					done = 1'b1;
				end
			end else begin
				st_d.in_sync       = 1'b0;
				st_d.half_bit_seen = 1'b0;
				st_d.byte_aligned  = 1'b0;
				st_d.bit_history   = '0;
			end
			if (done) begin
				st_d.bit_history = {st_q.bit_history[BYTE_W-2:0], level};
			end
			if (st_d.byte_aligned && done) begin
				if (st_q.bit_index == IDX_W'(BYTE_W-1)) begin
					emit            = 1'b1;
					st_d.bit_index  = '0;
					st_d.byte_accum = '0;
				end else begin
					st_d.bit_index  = st_q.bit_index + 1'b1;
					st_d.byte_accum = acc_sh;
				end
			end
			// preamble match also runs after a drop to idle on a bad width
			if (!skip_match && !st_d.byte_aligned && st_d.bit_history == preamble) begin
				st_d.byte_aligned = 1'b1;
				st_d.bit_index    = '0;
				st_d.byte_accum   = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (step) begin
			st_q <= st_d;
		end
	end

	a_half_needs_sync: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.half_bit_seen |-> st_q.in_sync)
		else $error("half-bit flag set outside bit sync");

	a_emit_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(step && emit) |-> (st_q.byte_aligned && st_q.in_sync
			&& st_q.bit_index == IDX_W'(BYTE_W-1)))
		else $error("byte emitted without alignment");

	a_timeout_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && tmo) |=> (!st_q.in_sync && !st_q.byte_aligned && st_q.bit_history == '0))
		else $error("timeout did not clear sync");

endmodule

FILE: test/manchester_pulse_decoder_chk.sv
// Scoreboard for the Manchester pulse decoder: predicts received bytes and compares them.
`timescale 1ns / 100ps
module manchester_pulse_decoder_chk import mpd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [TICK_W-1:0]    pulse_ticks,
	input  logic                 line_level,
	input  logic                 timed_out,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [BYTE_W-1:0]    rx_byte,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [TICK_W-1:0]    cfg_data,
	output int                   mismatches,
	output int                   bytes_pending
);

	logic [TICK_W-1:0] short_min;
	logic [TICK_W-1:0] short_max;
	logic [BYTE_W-1:0] preamble;
	dec_state_t        st;
	logic [BYTE_W-1:0] expected_bytes[$];

	task automatic drop_sync();
		st.in_sync       = 1'b0;
		st.half_bit_seen = 1'b0;
		st.byte_aligned  = 1'b0;
	endtask

	task automatic decode_edge(input logic [TICK_W-1:0] ticks, input logic level,
			input logic tmo, output logic got, output logic [BYTE_W-1:0] value);
		pulse_class_t cls;
		logic bit_done;
		logic mid_bit_loss;
		got = 1'b0;
		value = '0;
		bit_done = 1'b0;
		mid_bit_loss = 1'b0;
		cls.is_short = ticks >= short_min && ticks <= short_max;
		// long window bounds are doubled in 17 bits, no wrap
		cls.is_long = {1'b0, ticks} >= {short_min, 1'b0} && {1'b0, ticks} <= {short_max, 1'b0};
		if (tmo) begin
			drop_sync();
			st.bit_history = '0;
		end else if (!st.in_sync) begin
			if (cls.is_long) begin
				st.in_sync = 1'b1;
				st.bit_history = {{(BYTE_W-1){1'b0}}, level};
			end
		end else begin
			if (cls.is_short) begin
				bit_done = st.half_bit_seen;
				st.half_bit_seen = !st.half_bit_seen;
			end else if (cls.is_long) begin
				if (st.half_bit_seen) begin
					// history kept, no preamble check on this edge
					drop_sync();
					mid_bit_loss = 1'b1;
				end else begin
					bit_done = 1'b1;
				end
			end else begin
				drop_sync();
				st.bit_history = '0;
			end
			if (!mid_bit_loss) begin
				if (bit_done)
					st.bit_history = {st.bit_history[BYTE_W-2:0], level};
				if (st.byte_aligned && bit_done) begin
					st.byte_accum = {st.byte_accum[BYTE_W-2:0], level};
					if (st.bit_index == IDX_W'(7)) begin
						value = st.byte_accum;
						got = 1'b1;
						st.bit_index = '0;
						st.byte_accum = '0;
					end else begin
						st.bit_index = st.bit_index + 1'b1;
					end
				end
				if (!st.byte_aligned && st.bit_history == preamble) begin
					st.byte_aligned = 1'b1;
					st.bit_index = '0;
					st.byte_accum = '0;
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : scoreboard
		logic got;
		logic [BYTE_W-1:0] value;
		logic [BYTE_W-1:0] want;
		if (!arst_n) begin
			short_min = SHORT_MIN_RST;
			short_max = SHORT_MAX_RST;
			preamble = PREAMBLE_RST;
			st = '0;
			expected_bytes.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SHORT_MIN: short_min = cfg_data;
					CFG_SHORT_MAX: short_max = cfg_data;
					CFG_PREAMBLE:  preamble = cfg_data[BYTE_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				decode_edge(pulse_ticks, line_level, timed_out, got, value);
				if (got)
					expected_bytes.push_back(value);
			end
			if (out_valid && out_ready) begin
				if (expected_bytes.size() == 0) begin
					$error("rx_byte: expected none, actual %02h", rx_byte);
					mismatches++;
				end else begin
					want = expected_bytes.pop_front();
					if (rx_byte !== want) begin
						$error("rx_byte: expected %02h, actual %02h", want, rx_byte);
						mismatches++;
					end
				end
			end
		end
		bytes_pending = expected_bytes.size();
	end

endmodule

FILE: test/manchester_pulse_decoder_tb.sv
// Testbench top for the Manchester pulse decoder: edge, byte and register stimulus.
`timescale 1ns / 100ps
module manchester_pulse_decoder_tb;
	import mpd_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // unmapped register index
	localparam logic [BYTE_W-1:0] DEMO_BYTE = 8'hC3;
	localparam int STALL_LIMIT = 2000;
	localparam int EDGE_TARGET = 1700;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [TICK_W-1:0]    pulse_ticks;
	logic                 line_level;
	logic                 timed_out;
	logic                 out_valid;
	logic                 out_ready;
	logic [BYTE_W-1:0]    rx_byte;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TICK_W-1:0]    cfg_data;

	int mismatches;
	int bytes_pending;
	int idle_cycles;
	int edges_sent;
	logic [TICK_W-1:0] cur_min;
	logic [TICK_W-1:0] cur_max;
	logic [BYTE_W-1:0] cur_pre;
	bit calm;   // no idling on either side
	bit live;   // settings under which frames can decode

	manchester_pulse_decoder uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.pulse_ticks(pulse_ticks), .line_level(line_level), .timed_out(timed_out),
		.out_valid(out_valid), .out_ready(out_ready), .rx_byte(rx_byte),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	manchester_pulse_decoder_chk chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.pulse_ticks(pulse_ticks), .line_level(line_level), .timed_out(timed_out),
		.out_valid(out_valid), .out_ready(out_ready), .rx_byte(rx_byte),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .bytes_pending(bytes_pending)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// byte sink: random stall before each transaction
	initial begin : byte_sink
		int gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			gap = calm ? 0 : $urandom_range(0, 19);
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	function automatic logic [TICK_W-1:0] half_width();
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, 1) ? cur_max : cur_min;
		return 16'($urandom_range(cur_min, cur_max));
	endfunction

	function automatic logic [TICK_W-1:0] full_width();
		int lo;
		int hi;
		lo = 2 * int'(cur_min);
		hi = 2 * int'(cur_max);
		if (hi > 65535)
			hi = 65535;
		if (lo > hi)
			return 16'($urandom_range(0, 65535));
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, 1) ? 16'(hi) : 16'(lo);
		return 16'($urandom_range(lo, hi));
	endfunction

	task automatic send_edge(input logic [TICK_W-1:0] ticks, input logic level,
			input logic tmo);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 19);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		pulse_ticks <= ticks;
		line_level <= level;
		timed_out <= tmo;
		do @(posedge clk); while (!in_ready);
		if (live)
			edges_sent++;
	endtask

	// one data bit: a whole-bit pulse, or two half-bit pulses with the bit on the second
	task automatic send_bit(input logic value, input logic halves);
		if (halves) begin
			send_edge(half_width(), 1'($urandom_range(0, 1)), 1'b0);
			send_edge(half_width(), value, 1'b0);
		end else begin
			send_edge(full_width(), value, 1'b0);
		end
	endtask

	task automatic send_bits(input logic [BYTE_W-1:0] value, input int first);
		int i;
		for (i = first; i >= 0; i--) begin
			if ($urandom_range(0, 49) == 0) begin
				case ($urandom_range(0, 2))
					0: send_edge(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)), 1'b1);
					1: begin
						// long pulse after half a bit
						send_edge(half_width(), 1'($urandom_range(0, 1)), 1'b0);
						send_edge(full_width(), 1'($urandom_range(0, 1)), 1'b0);
					end
					default: send_edge(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)), 1'b0);
				endcase
			end
			send_bit(value[i], 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic send_frame();
		int nbytes;
		nbytes = $urandom_range(1, 4);
		if ($urandom_range(0, 3) == 0)
			send_edge(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)));
		// sync pulse carries the first preamble bit
		send_edge(full_width(), cur_pre[BYTE_W-1], 1'b0);
		send_bits(cur_pre, BYTE_W - 2);
		repeat (nbytes) send_bits(8'($urandom_range(0, 255)), BYTE_W - 1);
		if ($urandom_range(0, 1) == 0)
			send_edge(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)), 1'b1);
	endtask

	// stop sending until every byte is out and the pipeline has emptied
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (bytes_pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_settings(input logic [TICK_W-1:0] lo, input logic [TICK_W-1:0] hi,
			input logic [BYTE_W-1:0] pre);
		settle();
		write_reg(CFG_SHORT_MIN, lo);
		write_reg(CFG_SHORT_MAX, hi);
		write_reg(CFG_PREAMBLE, {8'($urandom_range(0, 255)), pre});
		@(negedge clk);
		cfg_valid <= 1'b0;
		cur_min = lo;
		cur_max = hi;
		cur_pre = pre;
	endtask

	initial begin
		int i;
		int phase;
		int sel;
		int lo;
		int hi;
		logic [BYTE_W-1:0] pre;
		arst_n = 1'b0;
		in_valid = 1'b0;
		pulse_ticks = '0;
		line_level = 1'b0;
		timed_out = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_SHORT_MIN;
		cfg_data = '0;
		calm = 1'b0;
		live = 1'b1;
		cur_min = SHORT_MIN_RST;
		cur_max = SHORT_MAX_RST;
		cur_pre = PREAMBLE_RST;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// directed: ignored widths, timeout, mid-bit long, bad width, then a framed byte
		send_edge(16'd0, 1'b0, 1'b0);
		send_edge(16'hFFFF, 1'b1, 1'b1);
		send_edge(16'd500, 1'b1, 1'b0);
		send_edge(16'd1000, 1'b1, 1'b0);
		send_edge(16'd400, 1'b0, 1'b0);
		send_edge(16'd1000, 1'b1, 1'b0);
		send_edge(16'd720, 1'b1, 1'b0);
		send_edge(16'hFFFF, 1'b0, 1'b0);
		send_edge(16'd1360, PREAMBLE_RST[BYTE_W-1], 1'b0);
		for (i = BYTE_W - 2; i >= 0; i--)
			send_bit(PREAMBLE_RST[i], i == 3);
		for (i = BYTE_W - 1; i >= 0; i--)
			send_bit(DEMO_BYTE[i], 1'b0);

		settle();
		write_reg(CFG_SPARE, 16'($urandom_range(0, 65535)));
		@(negedge clk);
		cfg_valid <= 1'b0;

		phase = 0;
		while (edges_sent < EDGE_TARGET) begin
			sel = phase < 3 ? phase : $urandom_range(3, 12);
			live = 1'b1;
			case ($urandom_range(0, 5))
				0: pre = 8'h00;
				1: pre = 8'hFF;
				2: pre = PREAMBLE_RST;
				default: pre = 8'($urandom_range(0, 255));
			endcase
			case (sel)
				0: begin
					// everything falls in the short window
					lo = 0;
					hi = 65535;
					pre = 8'h00;
					live = 1'b0;
				end
				1: begin
					// inverted windows match nothing
					lo = 65535;
					hi = 0;
					pre = 8'hFF;
					live = 1'b0;
				end
				2: begin
					lo = 0;
					hi = 0;
					pre = 8'hFF;
				end
				3, 4: begin
					lo = $urandom_range(16384, 32767);
					hi = $urandom_range(lo, (2 * lo - 1) > 32767 ? 32767 : 2 * lo - 1);
				end
				5: begin
					lo = $urandom_range(1, 3);
					hi = $urandom_range(lo, 2 * lo - 1);
				end
				6, 7: begin
					// overlapping windows: short wins
					lo = $urandom_range(50, 500);
					hi = $urandom_range(2 * lo, 4 * lo);
				end
				default: begin
					lo = $urandom_range(100, 2000);
					hi = $urandom_range(lo, 2 * lo - 1);
				end
			endcase
			load_settings(16'(lo), 16'(hi), pre);
			calm = $urandom_range(0, 3) == 0;
			if (!live) begin
				repeat (20)
					send_edge(16'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
			end else begin
				repeat ($urandom_range(3, 8)) send_frame();
			end
			phase++;
		end

		calm = 1'b0;
		settle();
		repeat (8) @(negedge clk);
		if (mismatches == 0 && bytes_pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
